>>> design/expiry_ordered_timer_queue_core_macros.svh
// Assertion macros used by the timer queue checker.
`ifndef EXPIRY_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH
`define EXPIRY_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define EOTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication, disabled while reset is held.
`define EOTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

>>> design/eotq_pkg.sv
// Shared types and constants of the expiry-ordered timer queue.
package eotq_pkg;

    localparam int DEPTH          = 32;
    localparam int PAYLOAD_BITS   = 64;
    localparam int TIME_W         = 32;
    localparam int PAYLOAD_PORT_W = 64;
    localparam int COUNT_W        = 6;
    localparam int CNT_W          = $clog2(DEPTH + 1);

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One held entry
    typedef struct packed {
        logic [TIME_W-1:0]       expiry;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

>>> design/eotq_cell.sv
// One cell of the sorted shift chain: holds one entry and keeps it, takes the new one, or takes a neighbour's.
module eotq_cell (
    input  logic                i_clk,
    input  eotq_pkg::t_cell_ctrl i_ctrl,
    input  eotq_pkg::t_entry    i_new,
    input  logic                i_occ,
    input  logic                i_prev_less,
    input  eotq_pkg::t_entry    i_prev,
    input  eotq_pkg::t_entry    i_next,
    output eotq_pkg::t_entry    o_entry,
    output logic                o_less
);
    import eotq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Held entry leaves strictly earlier than the incoming one
    assign o_less  = i_occ && (r_entry.expiry < i_new.expiry);
    assign o_entry = r_entry;

    // Keep, take the new beat, or shift one place along the chain
    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.rem) begin
            n_entry = i_next;
        end else if (i_ctrl.ins) begin
            priority if (o_less) begin
                n_entry = r_entry;
            end else if (i_prev_less) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> design/expiry_ordered_timer_queue_core.sv
// Top level of the expiry-ordered timer queue.
// Sorted queue of up to DEPTH timer entries built as a chain of cells, with cell 0
// always holding the entry that leaves next (earliest expiry, most recent among
// equal times). The busy output never rises, so a command may be given in every
// cycle, and its result appears on the output ports in the following cycle for
// that one cycle only, marked by o_done; the receiver must take it then. Every cell
// compares its held expiry against the incoming one in parallel. Inserts into a
// full queue and removes from an empty queue are refused with a status; o_count
// gives the number held after the beat.
module expiry_ordered_timer_queue_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [eotq_pkg::TIME_W-1:0]         i_expiry_time,
    input  logic [eotq_pkg::PAYLOAD_PORT_W-1:0] i_payload,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [eotq_pkg::TIME_W-1:0]         o_out_time,
    output logic [eotq_pkg::PAYLOAD_PORT_W-1:0] o_out_payload,
    output logic [eotq_pkg::COUNT_W-1:0]        o_count
);
    import eotq_pkg::*;

    logic                        accept;
    logic                        full;
    logic                        empty;
    t_cell_ctrl                  ctrl;
    t_entry                      new_entry;
    t_entry                      cell_q [DEPTH];
    logic                        cell_less [DEPTH];

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_done;
    t_status                     r_status;
    t_status                     n_status;
    logic [TIME_W-1:0]           r_out_time;
    logic [TIME_W-1:0]           n_out_time;
    logic [PAYLOAD_BITS-1:0]     r_out_payload;
    logic [PAYLOAD_BITS-1:0]     n_out_payload;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    assign new_entry.expiry  = i_expiry_time;
    assign new_entry.payload = i_payload[PAYLOAD_BITS-1:0];

    // Decode the beat into a chain command and the result fields
    always_comb begin
        ctrl          = '0;
        n_count       = r_count;
        n_status      = ST_OK;
        n_out_time    = '0;
        n_out_payload = '0;
        unique case (t_op'(i_op))
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.rem      = accept;
                    n_count       = r_count - CNT_W'(1);
                    n_out_time    = cell_q[0].expiry;
                    n_out_payload = cell_q[0].payload;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Cell chain; cell 0 sits at the head of the queue
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic   occ;
        logic   prev_less;
        t_entry prev_entry;
        t_entry next_entry;

        assign occ = (r_count > IDX);

        if (g == 0) begin : g_head
            assign prev_less  = 1'b1;
            assign prev_entry = new_entry;
        end else begin : g_body
            assign prev_less  = cell_less[g-1];
            assign prev_entry = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_entry = new_entry;
        end else begin : g_mid
            assign next_entry = cell_q[g+1];
        end

        eotq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new       (new_entry),
            .i_occ       (occ),
            .i_prev_less (prev_less),
            .i_prev      (prev_entry),
            .i_next      (next_entry),
            .o_entry     (cell_q[g]),
            .o_less      (cell_less[g])
        );
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_out_time    <= n_out_time;
            r_out_payload <= n_out_payload;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_time    = r_out_time;
    assign o_out_payload = PAYLOAD_PORT_W'(r_out_payload);
    assign o_count       = COUNT_W'(r_count);

endmodule

>>> design/eotq_checker.sv
// Port-level checks of the timer queue, bound to the top level.
`include "expiry_ordered_timer_queue_core_macros.svh"

module eotq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_done,
    input  logic [1:0]                          o_status,
    input  logic [eotq_pkg::TIME_W-1:0]         o_out_time,
    input  logic [eotq_pkg::PAYLOAD_PORT_W-1:0] o_out_payload,
    input  logic [eotq_pkg::COUNT_W-1:0]        o_count
);
    import eotq_pkg::*;

    // Every accepted beat gives exactly one result in the next cycle
    `EOTQ_ASSERT_NXT(a_done_follows, i_clk, i_rst_n, start && !busy, o_done)
    `EOTQ_ASSERT_NXT(a_no_stray_done, i_clk, i_rst_n, !(start && !busy), !o_done)

    // A refused insert only when the queue is full
    `EOTQ_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_done && (o_status == ST_FULL), o_count == COUNT_W'(DEPTH))

    // A refused remove leaves an empty queue and no data
    `EOTQ_ASSERT_IMP(a_empty_result, i_clk, i_rst_n, o_done && (o_status == ST_EMPTY), (o_count == '0) && (o_out_time == '0) && (o_out_payload == '0))

endmodule

bind expiry_ordered_timer_queue_core eotq_checker u_eotq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_out_time    (o_out_time),
    .o_out_payload (o_out_payload),
    .o_count       (o_count)
);

>>> tb/tb_expiry_ordered_timer_queue_core.sv
// Self-checking testbench for the expiry-ordered timer queue core.
`timescale 1ns / 100ps

module tb_expiry_ordered_timer_queue_core;
    import eotq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BEATS  = 450;
    localparam int SWING_BEATS  = 60;
    localparam logic [PAYLOAD_PORT_W-1:0] PAYLOAD_MASK =
        {PAYLOAD_PORT_W{1'b1}} >> (PAYLOAD_PORT_W - PAYLOAD_BITS);

    // One expected result beat
    typedef struct {
        t_status                   status;
        logic [TIME_W-1:0]         expiry;
        logic [PAYLOAD_PORT_W-1:0] payload;
        logic [COUNT_W-1:0]        count;
    } t_outcome;

    // Mirror of the queue contents plus the results still owed by the block
    class timer_mirror;
        t_entry   held[$];      // descending expiry, back is next to leave
        t_outcome owed[$];
        int       mismatches;

        function void note_command(t_op op, logic [TIME_W-1:0] expiry,
                                   logic [PAYLOAD_PORT_W-1:0] payload);
            t_outcome res;
            t_entry   ent;
            int       pos;
            res = '{status: ST_OK, expiry: '0, payload: '0, count: '0};
            if (op == OP_INSERT) begin
                if (held.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // new entry goes after every entry with equal or later expiry
                    pos = 0;
                    while (pos < held.size() && held[pos].expiry >= expiry)
                        pos++;
                    ent.expiry  = expiry;
                    ent.payload = payload[PAYLOAD_BITS-1:0];
                    held.insert(pos, ent);
                end
            end else if (held.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                ent         = held.pop_back();
                res.expiry  = ent.expiry;
                res.payload = PAYLOAD_PORT_W'(ent.payload) & PAYLOAD_MASK;
            end
            res.count = COUNT_W'(held.size());
            owed.push_back(res);
        endfunction

        function void check_outcome(logic [1:0] status, logic [TIME_W-1:0] expiry,
                                    logic [PAYLOAD_PORT_W-1:0] payload,
                                    logic [COUNT_W-1:0] count);
            t_outcome exp_res;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: unexpected result status=%0d time=%h count=%0d",
                             $realtime, status, expiry, count);
                return;
            end
            exp_res = owed.pop_front();
            if (status !== exp_res.status || expiry !== exp_res.expiry ||
                payload !== exp_res.payload || count !== exp_res.count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("ERROR %0t: expected status=%0d time=%h payload=%h count=%0d,",
                           $realtime, exp_res.status, exp_res.expiry, exp_res.payload,
                           exp_res.count);
                    $display(" got status=%0d time=%h payload=%h count=%0d",
                             status, expiry, payload, count);
                end
            end
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      start         = 1'b0;
    logic                      i_op          = OP_INSERT;
    logic [TIME_W-1:0]         i_expiry_time = '0;
    logic [PAYLOAD_PORT_W-1:0] i_payload     = '0;
    logic                      busy;
    logic                      o_done;
    logic [1:0]                o_status;
    logic [TIME_W-1:0]         o_out_time;
    logic [PAYLOAD_PORT_W-1:0] o_out_payload;
    logic [COUNT_W-1:0]        o_count;

    timer_mirror mirror = new;
    int          idle_pct = 0;
    int          quiet_cycles = 0;

    expiry_ordered_timer_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_expiry_time (i_expiry_time),
        .i_payload     (i_payload),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_out_time    (o_out_time),
        .o_out_payload (o_out_payload),
        .o_count       (o_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Check result beats first, then note the command beat of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1)
                mirror.check_outcome(o_status, o_out_time, o_out_payload, o_count);
            if (start && busy === 1'b0)
                mirror.note_command(t_op'(i_op), i_expiry_time, i_payload);
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one command, with random idle cycles in front, and wait until it is taken
    task automatic send_command(input t_op op, input logic [TIME_W-1:0] expiry,
                                input logic [PAYLOAD_PORT_W-1:0] payload);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_expiry_time <= expiry;
        i_payload     <= payload;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Mix of tight ranges (equal times likely), near-max values and full range
    function automatic logic [TIME_W-1:0] pick_expiry();
        case ($urandom_range(3))
            0: return TIME_W'($urandom_range(7));
            1: return {TIME_W{1'b1}} - TIME_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_op op;
        int  fill_pct;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty remove, extremes, equal-time ordering, drain to empty
        send_command(OP_REMOVE, '1, '1);
        send_command(OP_INSERT, 32'd5, 64'h0000_0000_0000_00A1);
        send_command(OP_INSERT, 32'd5, 64'h0000_0000_0000_00B2);
        send_command(OP_INSERT, '0, '0);
        send_command(OP_INSERT, '1, '1);
        send_command(OP_INSERT, 32'd5, 64'h5555_AAAA_5555_AAAA);
        send_command(OP_INSERT, 32'h8000_0000, 64'hAAAA_5555_AAAA_5555);
        send_command(OP_INSERT, '0, 64'h8000_0000_0000_0001);
        repeat (8) send_command(OP_REMOVE, '0, '0);
        send_command(OP_REMOVE, 32'h1234_5678, 64'hDEAD_BEEF_0123_4567);
        send_command(OP_INSERT, 32'd9, 64'h1);
        send_command(OP_REMOVE, '1, '1);
        send_command(OP_REMOVE, '0, '0);

        // Random: swing between filling and draining so full and empty both occur
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 37 : (phase == 1) ? 64 : 0;
            for (int i = 0; i < PHASE_BEATS; i++) begin
                fill_pct = ((i / SWING_BEATS) % 2 == 0) ? 85 : 15;
                op = ($urandom_range(99) < fill_pct) ? OP_INSERT : OP_REMOVE;
                send_command(op, pick_expiry(), {$urandom, $urandom});
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then wait for any stray beat
        while (mirror.owed.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mirror.mismatches == 0 && mirror.owed.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/eotq_pkg.sv
design/eotq_cell.sv
design/expiry_ordered_timer_queue_core.sv
design/eotq_checker.sv
tb/tb_expiry_ordered_timer_queue_core.sv
